// ===== hw/rtl/tcab_pkg.sv =====
// ----------------------------------------------------------------------------
// tcab_pkg
// Shared types, codes and helpers for the text coverage alpha blender:
// format codes, register indexes, coverage-to-alpha table, unpack and repack.
// ----------------------------------------------------------------------------
package tcab_pkg;

   localparam int PixelWidth = 24;
   localparam int ChanWidth  = 8;
   localparam int CovWidth   = 3;
   localparam int FmtWidth   = 2;
   localparam int IndexWidth = 2;

   typedef logic [PixelWidth-1:0] pixel_type;
   typedef logic [ChanWidth-1:0]  chan_type;
   typedef logic [FmtWidth-1:0]   fmt_type;

   // pixel format codes
   localparam fmt_type FMT_RGB565 = 2'd0;
   localparam fmt_type FMT_RGB555 = 2'd1;
   localparam fmt_type FMT_RGB888 = 2'd2;
   localparam fmt_type FMT_MONO   = 2'd3;

   // configuration register indexes
   localparam logic [IndexWidth-1:0] REG_FOREGROUND_COLOR = 2'd0;
   localparam logic [IndexWidth-1:0] REG_PIXEL_FORMAT     = 2'd1;

   // alpha levels
   localparam chan_type ALPHA_NONE = 8'd0;
   localparam chan_type ALPHA_FULL = 8'hff;

   typedef struct packed {
      chan_type r;
      chan_type g;
      chan_type b;
   } rgb_type;

   // map a coverage level to alpha; levels above four saturate
   function automatic chan_type alpha_of_level(input logic [CovWidth-1:0] level);
      chan_type a;
      case (level)
         3'd0:    a = ALPHA_NONE;
         3'd1:    a = 8'd64;
         3'd2:    a = 8'd128;
         3'd3:    a = 8'd192;
         default: a = ALPHA_FULL;
      endcase
      return a;
   endfunction

   // split a packed pixel into 8-bit channels
   function automatic rgb_type unpack(input pixel_type p, input fmt_type fmt);
      rgb_type c;
      unique case (fmt)
         FMT_RGB565: begin
            c.r = {p[15:11], 3'b000};
            c.g = {p[10:5], 2'b00};
            c.b = {p[4:0], 3'b000};
         end
         FMT_RGB555: begin
            c.r = {p[14:10], 3'b000};
            c.g = {p[9:5], 3'b000};
            c.b = {p[4:0], 3'b000};
         end
         default: begin
            c.r = p[23:16];
            c.g = p[15:8];
            c.b = p[7:0];
         end
      endcase
      return c;
   endfunction

   // join 8-bit channels into a packed pixel
   function automatic pixel_type pack(input rgb_type c, input fmt_type fmt);
      pixel_type p;
      unique case (fmt)
         FMT_RGB565: p = {8'd0, c.r[7:3], c.g[7:2], c.b[7:3]};
         FMT_RGB555: p = {9'd0, c.r[7:3], c.g[7:3], c.b[7:3]};
         default:    p = {c.r, c.g, c.b};
      endcase
      return p;
   endfunction

endpackage

// ===== hw/rtl/text_coverage_alpha_blend_top.sv =====
// ----------------------------------------------------------------------------
// text_coverage_alpha_blend_top
// Blends the text foreground color into a framebuffer pixel according to a
// five-level glyph coverage value, in RGB565, RGB555, RGB888 or mono format.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   flow
//   -------   -------------------------------------   -----------------------
//   request   start, busy, req_coverage,              one beat per cycle
//             req_dest_pixel
//   response  rsp_valid, rsp_result_pixel,            one-cycle strobe
//             rsp_write_enable
//   csr       csr_write_enable, csr_index,            write only, no wait
//             csr_write_data
//
// A beat passes through four register stages in order: unpack and difference,
// channel multiply, rounding step, add and repack. A new beat is taken every
// cycle (busy stays low). Synchronous reset clears the pipeline valid bits
// and both registers. The receiver cannot stall, so nothing holds.
// ----------------------------------------------------------------------------
module text_coverage_alpha_blend_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tcab_pkg::CovWidth-1:0]       req_coverage,
   input  tcab_pkg::pixel_type                 req_dest_pixel,
   output logic                                rsp_valid,
   output tcab_pkg::pixel_type                 rsp_result_pixel,
   output logic                                rsp_write_enable,
   input  logic                                csr_write_enable,
   input  logic [tcab_pkg::IndexWidth-1:0]     csr_index,
   input  tcab_pkg::pixel_type                 csr_write_data
);

   // configuration registers
   tcab_pkg::pixel_type fg_ff, fg_in;
   tcab_pkg::fmt_type   fmt_ff, fmt_in;

   // stage 1: unpacked destination, differences, alpha
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_blend_ff, s1_blend_in;
   logic                s1_wr_ff, s1_wr_in;
   tcab_pkg::pixel_type s1_bypass_ff, s1_bypass_in;
   tcab_pkg::fmt_type   s1_fmt_ff, s1_fmt_in;
   tcab_pkg::chan_type  s1_alpha_ff, s1_alpha_in;
   tcab_pkg::rgb_type   s1_dst_ff, s1_dst_in;
   logic signed [8:0]   s1_diff_ff [3];
   logic signed [8:0]   s1_diff_in [3];

   // stage 2: products
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_blend_ff, s2_blend_in;
   logic                s2_wr_ff, s2_wr_in;
   tcab_pkg::pixel_type s2_bypass_ff, s2_bypass_in;
   tcab_pkg::fmt_type   s2_fmt_ff, s2_fmt_in;
   tcab_pkg::rgb_type   s2_dst_ff, s2_dst_in;
   logic signed [17:0]  s2_prod_ff [3];
   logic signed [17:0]  s2_prod_in [3];

   // stage 3: rounded steps
   logic                s3_valid_ff, s3_valid_in;
   logic                s3_blend_ff, s3_blend_in;
   logic                s3_wr_ff, s3_wr_in;
   tcab_pkg::pixel_type s3_bypass_ff, s3_bypass_in;
   tcab_pkg::fmt_type   s3_fmt_ff, s3_fmt_in;
   tcab_pkg::rgb_type   s3_dst_ff, s3_dst_in;
   tcab_pkg::chan_type  s3_step_ff [3];
   tcab_pkg::chan_type  s3_step_in [3];

   // output register
   logic                out_valid_ff, out_valid_in;
   logic                out_wr_ff, out_wr_in;
   tcab_pkg::pixel_type out_pixel_ff, out_pixel_in;

   logic                accept;
   tcab_pkg::chan_type  alpha;
   tcab_pkg::rgb_type   fg_rgb;
   tcab_pkg::rgb_type   dst_rgb;
   tcab_pkg::rgb_type   blended;
   logic signed [17:0]  round_sum [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // decode configuration writes
   always_comb begin
      fg_in  = fg_ff;
      fmt_in = fmt_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tcab_pkg::REG_FOREGROUND_COLOR: fg_in  = csr_write_data;
            tcab_pkg::REG_PIXEL_FORMAT:     fmt_in = csr_write_data[tcab_pkg::FmtWidth-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: classify the beat, unpack both colors, take differences
   always_comb begin
      alpha   = tcab_pkg::alpha_of_level(req_coverage);
      fg_rgb  = tcab_pkg::unpack(fg_ff, fmt_ff);
      dst_rgb = tcab_pkg::unpack(req_dest_pixel, fmt_ff);

      s1_valid_in  = accept;
      s1_wr_in     = (alpha != tcab_pkg::ALPHA_NONE);
      s1_blend_in  = (alpha != tcab_pkg::ALPHA_NONE) && (alpha != tcab_pkg::ALPHA_FULL)
                     && (fmt_ff != tcab_pkg::FMT_MONO);
      s1_bypass_in = (alpha == tcab_pkg::ALPHA_NONE) ? req_dest_pixel : fg_ff;
      s1_fmt_in    = fmt_ff;
      s1_alpha_in  = alpha;
      s1_dst_in    = dst_rgb;
      s1_diff_in[0] = $signed({1'b0, fg_rgb.r}) - $signed({1'b0, dst_rgb.r});
      s1_diff_in[1] = $signed({1'b0, fg_rgb.g}) - $signed({1'b0, dst_rgb.g});
      s1_diff_in[2] = $signed({1'b0, fg_rgb.b}) - $signed({1'b0, dst_rgb.b});
   end

   // stage 2: scale each difference by alpha
   always_comb begin
      s2_valid_in  = s1_valid_ff;
      s2_blend_in  = s1_blend_ff;
      s2_wr_in     = s1_wr_ff;
      s2_bypass_in = s1_bypass_ff;
      s2_fmt_in    = s1_fmt_ff;
      s2_dst_in    = s1_dst_ff;
      for (int i = 0; i < 3; i++) begin
         s2_prod_in[i] = 18'(s1_diff_ff[i]) * 18'($signed({1'b0, s1_alpha_ff}));
      end
   end

   // stage 3: divide by 255 with rounding, floor shifts
   always_comb begin
      s3_valid_in  = s2_valid_ff;
      s3_blend_in  = s2_blend_ff;
      s3_wr_in     = s2_wr_ff;
      s3_bypass_in = s2_bypass_ff;
      s3_fmt_in    = s2_fmt_ff;
      s3_dst_in    = s2_dst_ff;
      for (int i = 0; i < 3; i++) begin
         round_sum[i]  = s2_prod_ff[i] + (s2_prod_ff[i] >>> 8) + 18'sd128;
         s3_step_in[i] = round_sum[i][15:8];
      end
   end

   // stage 4: apply steps, repack, pick the bypass pixel where no blend
   always_comb begin
      blended.r    = s3_dst_ff.r + s3_step_ff[0];
      blended.g    = s3_dst_ff.g + s3_step_ff[1];
      blended.b    = s3_dst_ff.b + s3_step_ff[2];
      out_valid_in = s3_valid_ff;
      out_wr_in    = s3_wr_ff;
      out_pixel_in = s3_blend_ff ? tcab_pkg::pack(blended, s3_fmt_ff) : s3_bypass_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= '0;
         fmt_ff       <= tcab_pkg::FMT_RGB565;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fg_ff        <= fg_in;
         fmt_ff       <= fmt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers advance every cycle
   always_ff @(posedge clock) begin
      s1_blend_ff  <= s1_blend_in;
      s1_wr_ff     <= s1_wr_in;
      s1_bypass_ff <= s1_bypass_in;
      s1_fmt_ff    <= s1_fmt_in;
      s1_alpha_ff  <= s1_alpha_in;
      s1_dst_ff    <= s1_dst_in;
      s2_blend_ff  <= s2_blend_in;
      s2_wr_ff     <= s2_wr_in;
      s2_bypass_ff <= s2_bypass_in;
      s2_fmt_ff    <= s2_fmt_in;
      s2_dst_ff    <= s2_dst_in;
      s3_blend_ff  <= s3_blend_in;
      s3_wr_ff     <= s3_wr_in;
      s3_bypass_ff <= s3_bypass_in;
      s3_fmt_ff    <= s3_fmt_in;
      s3_dst_ff    <= s3_dst_in;
      out_wr_ff    <= out_wr_in;
      out_pixel_ff <= out_pixel_in;
      for (int i = 0; i < 3; i++) begin
         s1_diff_ff[i] <= s1_diff_in[i];
         s2_prod_ff[i] <= s2_prod_in[i];
         s3_step_ff[i] <= s3_step_in[i];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_pixel = out_pixel_ff;
   assign rsp_write_enable = out_wr_ff;

endmodule
